FILE: hdl/hpq_pkg.sv
// hpq_pkg: shared types and constants for the binary max-heap priority queue
// opcodes, status codes, controller states and default sizes
// no dependencies
`default_nettype none

package hpq_pkg;

    // default number of heap slots
    localparam int CAPACITY_DEFAULT = 127;

    // fixed field widths
    localparam int KEY_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 7;

    // opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM_RD,
        ST_REM_LOAD,
        ST_UP_CHECK,
        ST_UP_CMP,
        ST_DN_CHECK,
        ST_DN_CMP
    } state_t;

endpackage

`default_nettype wire

FILE: hdl/hpq_mem.sv
// hpq_mem: heap key storage, one write port and two registered read ports
// depends on hpq_pkg for the key width
`default_nettype none

module hpq_mem #(
    parameter int DEPTH = hpq_pkg::CAPACITY_DEFAULT + 2,
    parameter int AW    = $clog2(hpq_pkg::CAPACITY_DEFAULT + 2)
) (
    input  wire                                    clk,
    input  wire                                    we,
    input  wire        [AW-1:0]                    waddr,
    input  wire signed [hpq_pkg::KEY_W-1:0]        wdata,
    input  wire        [AW-1:0]                    raddr_a,
    input  wire        [AW-1:0]                    raddr_b,
    output logic signed [hpq_pkg::KEY_W-1:0]       rdata_a,
    output logic signed [hpq_pkg::KEY_W-1:0]       rdata_b
);
    import hpq_pkg::*;

    logic signed [KEY_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

FILE: hdl/binary_max_heap_priority_queue_unit.sv
// Binary max-heap priority queue of signed keys, stored one-based in hpq_mem.
// An error result comes straight from idle. An insert opens a hole at the end and sifts up;
// a remove reads the root and last entry, loads them and sifts down from the root.
// At most 6 levels are moved at 127 slots; each level is a read state then a compare/write.
// busy drops in the cycle done is shown, so the next beat can start there; no stall.
// Reset clears the entry count and controller; heap memory is not cleared.
`default_nettype none

module binary_max_heap_priority_queue_unit #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEFAULT
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    start,
    output logic                                   busy,
    input  wire                                    opcode,
    input  wire signed [hpq_pkg::KEY_W-1:0]        key_in,
    output logic                                   done,
    output logic signed [hpq_pkg::KEY_W-1:0]       key_out,
    output logic       [hpq_pkg::STATUS_W-1:0]     status,
    output logic       [hpq_pkg::ENTRIES_W-1:0]    entries
);
    import hpq_pkg::*;

    // slot zero unused, one spare slot above capacity for a right child probe
    localparam int DEPTH = CAPACITY + 2;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] CAP_A = AW'(CAPACITY);
    localparam logic [AW-1:0] ROOT  = AW'(1);

    state_t state_reg, state_next;

    logic [AW-1:0]              count_reg, count_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              left_reg, left_next;
    logic                       right_ok_reg, right_ok_next;
    logic signed [KEY_W-1:0]    key_reg, key_next;
    logic signed [KEY_W-1:0]    res_reg, res_next;
    logic                       done_reg, done_next;
    logic signed [KEY_W-1:0]    key_out_reg, key_out_next;
    logic [STATUS_W-1:0]        status_reg, status_next;
    logic [ENTRIES_W-1:0]       entries_reg, entries_next;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic signed [KEY_W-1:0]    mem_wdata;
    logic [AW-1:0]              mem_raddr_a;
    logic [AW-1:0]              mem_raddr_b;
    logic signed [KEY_W-1:0]    mem_rdata_a;
    logic signed [KEY_W-1:0]    mem_rdata_b;

    logic                       accept;
    logic [AW:0]                left_wide;
    logic                       take_right;
    logic signed [KEY_W-1:0]    big_val;
    logic [AW-1:0]              big_addr;

    assign accept = start && !busy;

    // child addresses and larger-child select
    assign left_wide  = {pos_reg, 1'b0};
    assign take_right = right_ok_reg && (mem_rdata_a < mem_rdata_b);
    assign big_val    = take_right ? mem_rdata_b : mem_rdata_a;
    assign big_addr   = take_right ? (left_reg + ROOT) : left_reg;

    // key storage
    hpq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_REMOVE)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = ST_REM_RD;
                        end
                    end
                    else if (count_reg < CAP_A)
                    begin
                        state_next = ST_UP_CHECK;
                    end
                end
            end
            ST_REM_RD:
            begin
                state_next = ST_REM_LOAD;
            end
            ST_REM_LOAD:
            begin
                state_next = ST_DN_CHECK;
            end
            ST_UP_CHECK:
            begin
                state_next = (pos_reg == ROOT) ? ST_IDLE : ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                state_next = (mem_rdata_a > key_reg) ? ST_IDLE : ST_UP_CHECK;
            end
            ST_DN_CHECK:
            begin
                state_next = (left_wide > {1'b0, count_reg}) ? ST_IDLE : ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                state_next = (key_reg >= big_val) ? ST_IDLE : ST_DN_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        right_ok_next = right_ok_reg;
        key_next      = key_reg;
        res_next      = res_reg;
        done_next     = 1'b0;
        key_out_next  = key_out_reg;
        status_next   = status_reg;
        entries_next  = entries_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = key_reg;
        mem_raddr_a   = ROOT;
        mem_raddr_b   = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next    = 1'b1;
                            key_out_next = '0;
                            status_next  = STATUS_EMPTY;
                            entries_next = ENTRIES_W'(count_reg);
                        end
                    end
                    else if (count_reg >= CAP_A)
                    begin
                        done_next    = 1'b1;
                        key_out_next = '0;
                        status_next  = STATUS_FULL;
                        entries_next = ENTRIES_W'(count_reg);
                    end
                    else
                    begin
                        // open a hole at the end of the heap
                        count_next = count_reg + ROOT;
                        pos_next   = count_reg + ROOT;
                        key_next   = key_in;
                        res_next   = '0;
                    end
                end
            end
            ST_REM_RD:
            begin
                // fetch root and last entry
                mem_raddr_a = ROOT;
                mem_raddr_b = count_reg;
            end
            ST_REM_LOAD:
            begin
                res_next   = mem_rdata_a;
                key_next   = mem_rdata_b;
                count_next = count_reg - ROOT;
                pos_next   = ROOT;
            end
            ST_UP_CHECK:
            begin
                mem_raddr_a = pos_reg >> 1;
                if (pos_reg == ROOT)
                begin
                    mem_we = 1'b1;
                end
            end
            ST_UP_CMP:
            begin
                if (mem_rdata_a > key_reg)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    // parent moves down into the hole
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_a;
                    pos_next  = pos_reg >> 1;
                end
            end
            ST_DN_CHECK:
            begin
                mem_raddr_a   = left_wide[AW-1:0];
                mem_raddr_b   = left_wide[AW-1:0] + ROOT;
                left_next     = left_wide[AW-1:0];
                right_ok_next = left_wide < {1'b0, count_reg};
                if (left_wide > {1'b0, count_reg})
                begin
                    mem_we = 1'b1;
                end
            end
            ST_DN_CMP:
            begin
                if (key_reg >= big_val)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    // larger child moves up into the hole
                    mem_we    = 1'b1;
                    mem_wdata = big_val;
                    pos_next  = big_addr;
                end
            end
            default:
            begin
            end
        endcase

        // finishing beat of a normal operation
        if (state_reg != ST_IDLE && state_next == ST_IDLE)
        begin
            done_next    = 1'b1;
            key_out_next = res_reg;
            status_next  = STATUS_OK;
            entries_next = ENTRIES_W'(count_reg);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        left_reg     <= left_next;
        right_ok_reg <= right_ok_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        key_out_reg  <= key_out_next;
        status_reg   <= status_next;
        entries_reg  <= entries_next;
    end

    // ports
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign key_out = key_out_reg;
    assign status  = status_reg;
    assign entries = entries_reg;

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_A)
        else $error("entry count above capacity");

    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted beat produced neither work nor result");

    a_error_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (key_out == '0))
        else $error("error result carries a nonzero key");
`endif

endmodule

`default_nettype wire

FILE: dv/hpq_checker.sv
// hpq_checker: watches the command and result beats of the heap priority queue,
// keeps its own heap to predict each result and compares field by field
// depends on hpq_pkg for field widths, opcodes and status codes
`default_nettype none

module hpq_checker #(
    parameter int CAPACITY = hpq_pkg::CAPACITY_DEFAULT
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    input  wire                                 busy,
    input  wire                                 opcode,
    input  wire signed [hpq_pkg::KEY_W-1:0]     key_in,
    input  wire                                 done,
    input  wire signed [hpq_pkg::KEY_W-1:0]     key_out,
    input  wire        [hpq_pkg::STATUS_W-1:0]  status,
    input  wire        [hpq_pkg::ENTRIES_W-1:0] entries,
    output int                                  fails,
    output int                                  awaiting,
    output int                                  results_seen,
    output int                                  rejects_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import hpq_pkg::*;

    typedef struct {
        logic signed [KEY_W-1:0]     key;
        logic        [STATUS_W-1:0]  code;
        logic        [ENTRIES_W-1:0] count;
    } heap_result_t;

    // private copy of the heap, one-based
    logic signed [KEY_W-1:0] heap_model [1:CAPACITY];
    int unsigned             model_count;
    heap_result_t            awaited_results [$];

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] want,
                                   input logic [KEY_W-1:0] got);
        fails++;
        $display("%0t hpq_checker: %s expected %h got %h", $time, what, want, got);
    endtask

    // apply one command beat to the heap copy and return the result it should give
    function automatic heap_result_t heap_apply(input logic op,
                                                input logic signed [KEY_W-1:0] key);
        heap_result_t            r;
        int unsigned             pos;
        int unsigned             parent;
        int unsigned             left;
        int unsigned             right;
        int unsigned             big;
        logic signed [KEY_W-1:0] t;
        r.key  = '0;
        r.code = STATUS_OK;
        if (op == OP_INSERT)
        begin
            if (model_count >= CAPACITY)
                r.code = STATUS_FULL;
            else
            begin
                // append and sift up, equal parent still swaps
                model_count++;
                heap_model[model_count] = key;
                pos = model_count;
                while (pos > 1)
                begin
                    parent = pos / 2;
                    if (heap_model[parent] > heap_model[pos])
                        break;
                    t                  = heap_model[pos];
                    heap_model[pos]    = heap_model[parent];
                    heap_model[parent] = t;
                    pos                = parent;
                end
            end
        end
        else
        begin
            if (model_count == 0)
                r.code = STATUS_EMPTY;
            else
            begin
                // take the root, move the last entry up and sift it down
                r.key         = heap_model[1];
                heap_model[1] = heap_model[model_count];
                model_count--;
                pos = 1;
                while (1)
                begin
                    left  = pos * 2;
                    right = left + 1;
                    if (left > model_count)
                        break;
                    big = left;
                    // right child only counts inside the heap, ties go left
                    if (right <= model_count && heap_model[left] < heap_model[right])
                        big = right;
                    if (heap_model[pos] >= heap_model[big])
                        break;
                    t               = heap_model[pos];
                    heap_model[pos] = heap_model[big];
                    heap_model[big] = t;
                    pos             = big;
                end
            end
        end
        r.count = model_count[ENTRIES_W-1:0];
        return r;
    endfunction

    // result beats are checked before a command beat of the same edge is queued
    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t want;
        heap_result_t fresh;
        if (!rst_n)
        begin
            model_count = 0;
            awaited_results.delete();
            awaiting = 0;
        end
        else
        begin
            if (done)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                    report_mismatch("result beat with nothing outstanding, key_out", '0,
                                    key_out);
                else
                begin
                    want = awaited_results.pop_front();
                    if (key_out !== want.key)
                        report_mismatch("key_out", want.key, key_out);
                    if (status !== want.code)
                        report_mismatch("status", KEY_W'(want.code), KEY_W'(status));
                    if (entries !== want.count)
                        report_mismatch("entries", KEY_W'(want.count), KEY_W'(entries));
                end
            end
            if (start && !busy)
            begin
                fresh = heap_apply(opcode, key_in);
                if (fresh.code != STATUS_OK)
                    rejects_seen++;
                awaited_results.push_back(fresh);
            end
            awaiting = awaited_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb_binary_max_heap_priority_queue_unit.sv
// tb_binary_max_heap_priority_queue_unit: drives insert and remove beats into the
// heap priority queue and gives the verdict; checking is done by hpq_checker
// depends on hpq_pkg, hpq_checker and binary_max_heap_priority_queue_unit
`default_nettype none

module tb_binary_max_heap_priority_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hpq_pkg::*;

    localparam int HEAP_SLOTS = CAPACITY_DEFAULT;
    localparam int BEAT_GOAL  = 1900;

    typedef enum int {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } phase_t;

    logic                    clk    = 1'b0;
    logic                    rst_n  = 1'b0;
    logic                    start  = 1'b0;
    logic                    opcode = 1'b0;
    logic signed [KEY_W-1:0] key_in = '0;

    wire                            busy;
    wire                            done;
    wire signed [KEY_W-1:0]         key_out;
    wire        [STATUS_W-1:0]      status;
    wire        [ENTRIES_W-1:0]     entries;

    int fails;
    int awaiting;
    int results_seen;
    int rejects_seen;

    int beats_sent;
    int inserts_sent;
    int removes_sent;
    int fill_level;
    int gap_ceiling;

    binary_max_heap_priority_queue_unit #(
        .CAPACITY(HEAP_SLOTS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .opcode (opcode),
        .key_in (key_in),
        .done   (done),
        .key_out(key_out),
        .status (status),
        .entries(entries)
    );

    hpq_checker #(
        .CAPACITY(HEAP_SLOTS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key_in      (key_in),
        .done        (done),
        .key_out     (key_out),
        .status      (status),
        .entries     (entries),
        .fails       (fails),
        .awaiting    (awaiting),
        .results_seen(results_seen),
        .rejects_seen(rejects_seen)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // reset held from the start, released on a falling edge
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("tb_binary_max_heap_priority_queue_unit: FAIL");
        $finish;
    end

    // boundary and tie keys
    function automatic logic signed [KEY_W-1:0] edge_key(input int idx);
        case (idx)
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'sd1;
            5:       return 32'sh5555_5555;
            6:       return 32'shaaaa_aaaa;
            default: return 32'sd7;
        endcase
    endfunction

    // wide random keys, a narrow band that makes many ties, and boundary values
    function automatic logic signed [KEY_W-1:0] pick_key();
        int band;
        case ($urandom_range(0, 3))
            0, 1:
                return $urandom();
            2:
            begin
                band = $urandom_range(0, 8);
                return band - 4;
            end
            default:
                return edge_key($urandom_range(0, 6));
        endcase
    endfunction

    // one command beat: optional idle gap, then hold start until accepted
    task automatic send_beat(input logic op, input logic signed [KEY_W-1:0] key);
        int gap;
        gap = $urandom_range(0, gap_ceiling);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start  = 1'b1;
        opcode = op;
        key_in = key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
        if (op == OP_INSERT)
        begin
            inserts_sent++;
            if (fill_level < HEAP_SLOTS)
                fill_level++;
        end
        else
        begin
            removes_sent++;
            if (fill_level > 0)
                fill_level--;
        end
    endtask

    // stop sending until every outstanding result beat has come back
    task automatic drain_results();
        start = 1'b0;
        while (awaiting != 0)
            @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        phase_t phase;
        int     span;
        int     insert_pct;
        logic   op;
        bit     first_phase;
        first_phase = 1'b1;
        gap_ceiling = 18;
        wait (rst_n);
        @(negedge clk);

        // directed: empty remove, boundary keys, ties, drain past empty
        send_beat(OP_REMOVE, $urandom());
        for (int i = 0; i < 10; i++)
            send_beat(OP_INSERT, edge_key(i));
        repeat (11) send_beat(OP_REMOVE, $urandom());
        drain_results();

        // random phases: insert-heavy runs sized to pass full, remove-heavy runs sized to pass empty, mixed
        while (beats_sent < BEAT_GOAL)
        begin
            if (first_phase)
                phase = PHASE_FILL;
            else
                phase = phase_t'($urandom_range(0, 2));
            first_phase = 1'b0;
            case (phase)
                PHASE_FILL:
                begin
                    span       = HEAP_SLOTS - fill_level + $urandom_range(2, 8);
                    insert_pct = 95;
                end
                PHASE_DRAIN:
                begin
                    span       = fill_level + $urandom_range(2, 8);
                    insert_pct = 5;
                end
                default:
                begin
                    span       = $urandom_range(20, 120);
                    insert_pct = $urandom_range(35, 65);
                end
            endcase
            gap_ceiling = ($urandom_range(0, 3) == 0) ? 0 : 18;
            repeat (span)
            begin
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                send_beat(op, pick_key());
            end
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end

        // wind down
        drain_results();
        repeat (20) @(posedge clk);
        $display("run covered %0d beats (%0d inserts, %0d removes), %0d results checked,",
                 beats_sent, inserts_sent, removes_sent, results_seen);
        $display("including %0d empty or full rejections; %0d mismatches",
                 rejects_seen, fails);
        if (fails == 0)
            $display("tb_binary_max_heap_priority_queue_unit: PASS");
        else
            $display("tb_binary_max_heap_priority_queue_unit: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: binary_max_heap_priority_queue_unit.f
hdl/hpq_pkg.sv
hdl/hpq_mem.sv
hdl/binary_max_heap_priority_queue_unit.sv
dv/hpq_checker.sv
dv/tb_binary_max_heap_priority_queue_unit.sv
